@@ design/dvr_pkg.sv @@
// ----------------------------------------------------------------------------
// dvr_pkg: shared types and constants for the distance-vector route update
// Request layouts, cost table shape, register indexes and cost saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package dvr_pkg;

  localparam int NODES  = 4;
  localparam int NODE_W = 2;
  localparam int COST_W = 10;
  localparam int IDX_W  = 3;

  localparam logic [COST_W-1:0] INFINITE_COST = 10'd999;

  typedef logic [NODES-1:0][COST_W-1:0] cost_vec_t;
  typedef logic [NODES-1:0][NODES-1:0][COST_W-1:0] cost_tbl_t;

  typedef enum logic {
    MODE_INIT   = 1'b0,
    MODE_UPDATE = 1'b1
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_OWN_NODE      = 3'd0,
    REG_NEIGHBOR_MASK = 3'd1,
    REG_LINK_COST_0   = 3'd2,
    REG_LINK_COST_1   = 3'd3,
    REG_LINK_COST_2   = 3'd4,
    REG_LINK_COST_3   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] sender_node;
    logic [COST_W-1:0] adv_cost_zero;
    logic [COST_W-1:0] adv_cost_one;
    logic [COST_W-1:0] adv_cost_two;
    logic [COST_W-1:0] adv_cost_three;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] dest_node;
    logic [NODE_W-1:0] from_node;
    logic [COST_W-1:0] best_cost_zero;
    logic [COST_W-1:0] best_cost_one;
    logic [COST_W-1:0] best_cost_two;
    logic [COST_W-1:0] best_cost_three;
    logic              last;
  } out_item_t;

  function automatic logic [COST_W-1:0] sat_cost(input logic [COST_W-1:0] v);
    return (v > INFINITE_COST) ? INFINITE_COST : v;
  endfunction

endpackage

`default_nettype wire

@@ design/dvr_best.sv @@
// ----------------------------------------------------------------------------
// dvr_best: least-cost path finder
// For each destination, the minimum over all via nodes of the direct cost to
// the via plus the via's cost to the destination, limited to infinity.
// ----------------------------------------------------------------------------
`default_nettype none

module dvr_best (
  input  dvr_pkg::cost_tbl_t           tbl,
  input  logic [dvr_pkg::NODE_W-1:0]   own,
  output dvr_pkg::cost_vec_t           best
);
  import dvr_pkg::*;

  always_comb begin
    logic [COST_W:0] b;
    logic [COST_W:0] c;
    best = '0;
    for (int d = 0; d < NODES; d++) begin
      b = {1'b0, INFINITE_COST};
      for (int v = 0; v < NODES; v++) begin
        if (NODE_W'(v) == own) begin
          c = {1'b0, tbl[own][d]};
        end else begin
          c = {1'b0, tbl[own][v]} + {1'b0, tbl[v][d]};
        end
        // Only a strictly smaller sum replaces the running best.
        if (c < b) begin
          b = c;
        end
      end
      best[d] = b[COST_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ design/distance_vector_route_update.sv @@
// ----------------------------------------------------------------------------
// distance_vector_route_update: one node of a four-node distance-vector router
// Keeps the 4x4 cost table, merges neighbor advertisements and sends the
// resulting best-cost vector to every neighbor.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid/in_ready) carry either an init (mode 0), which
//   reloads the own row from the link cost registers and clears the rest to
//   infinity, or an update (mode 1) that min-merges a neighbor's vector into
//   its row. An init, or an update that lowers any entry, produces one
//   output request (out_valid/out_ready) per neighbor in increasing node
//   order, with last set on the final one; an update that changes nothing
//   produces none.
//   A request waits in the input register; the table is updated and the best
//   costs computed in the cycle it leaves that register, and the first
//   packet is offered in the cycle after. The packets of a run, one per
//   neighbor (up to four), go out in turn as the receiver takes them; the
//   input register accepts the next request while a run is still being sent.
//   Reset clears the cost table to infinity and the configuration and
//   control registers to their defaults. When the receiver stalls, the
//   current packet holds and at most one further request waits in the input
//   register. Configuration (cfg_we/cfg_idx/cfg_wdata) is to be written by
//   the user only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_update (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dvr_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dvr_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [dvr_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [dvr_pkg::COST_W-1:0]  cfg_wdata
);
  import dvr_pkg::*;

  logic [NODE_W-1:0] own_node_r;
  logic [NODES-1:0]  neighbor_mask_r;
  cost_vec_t         link_cost_r;

  cost_tbl_t         table_r;
  cost_tbl_t         table_nxt;
  logic              hold_valid_r;
  logic              hold_valid_nxt;
  in_item_t          hold_r;
  logic [NODES-1:0]  run_mask_r;
  logic [NODES-1:0]  run_mask_nxt;
  cost_vec_t         best_r;
  logic [NODE_W-1:0] from_r;

  cost_vec_t         adv;
  cost_vec_t         best;
  logic              advertise;
  logic              process;
  logic              run_free;
  logic              out_fire;
  logic [NODES-1:0]  low_bit;
  logic [NODE_W-1:0] dest;
  logic              run_last;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_node_r      <= '0;
      neighbor_mask_r <= '0;
      link_cost_r     <= {NODES{INFINITE_COST}};
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OWN_NODE:      own_node_r      <= cfg_wdata[NODE_W-1:0];
        REG_NEIGHBOR_MASK: neighbor_mask_r <= cfg_wdata[NODES-1:0];
        REG_LINK_COST_0:   link_cost_r[0]  <= cfg_wdata;
        REG_LINK_COST_1:   link_cost_r[1]  <= cfg_wdata;
        REG_LINK_COST_2:   link_cost_r[2]  <= cfg_wdata;
        REG_LINK_COST_3:   link_cost_r[3]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Output run control.
  assign low_bit   = run_mask_r & (~run_mask_r + NODES'(1));
  assign run_last  = (run_mask_r == low_bit);
  assign out_valid = |run_mask_r;
  assign out_fire  = out_valid && out_ready;
  assign run_free  = !out_valid || (out_ready && run_last);
  assign in_ready  = !hold_valid_r || run_free;
  assign process   = hold_valid_r && run_free;

  always_comb begin
    dest = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (run_mask_r[i]) begin
        dest = NODE_W'(i);
      end
    end
  end

  // Table merge for the request in the input register.
  assign adv = {hold_r.adv_cost_three, hold_r.adv_cost_two,
                hold_r.adv_cost_one, hold_r.adv_cost_zero};

  always_comb begin
    logic [COST_W-1:0] a;
    table_nxt = table_r;
    advertise = 1'b0;
    a         = '0;
    if (hold_r.mode == MODE_INIT) begin
      table_nxt = {(NODES * NODES){INFINITE_COST}};
      for (int d = 0; d < NODES; d++) begin
        table_nxt[own_node_r][d] = sat_cost(link_cost_r[d]);
      end
      advertise = 1'b1;
    end else begin
      for (int d = 0; d < NODES; d++) begin
        a = sat_cost(adv[d]);
        if (table_r[hold_r.sender_node][d] > a) begin
          table_nxt[hold_r.sender_node][d] = a;
          advertise = 1'b1;
        end
      end
    end
  end

  dvr_best u_best (
    .tbl  (table_nxt),
    .own  (own_node_r),
    .best (best)
  );

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_valid && in_ready) begin
      hold_valid_nxt = 1'b1;
    end else if (process) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    run_mask_nxt = run_mask_r;
    if (process) begin
      run_mask_nxt = advertise ? neighbor_mask_r : '0;
    end else if (out_fire) begin
      run_mask_nxt = run_mask_r & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      run_mask_r   <= '0;
      table_r      <= {(NODES * NODES){INFINITE_COST}};
    end else begin
      hold_valid_r <= hold_valid_nxt;
      run_mask_r   <= run_mask_nxt;
      if (process) begin
        table_r <= table_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r <= in_data;
    end
    if (process) begin
      best_r <= best;
      from_r <= own_node_r;
    end
  end

  assign out_data.dest_node       = dest;
  assign out_data.from_node       = from_r;
  assign out_data.best_cost_zero  = best_r[0];
  assign out_data.best_cost_one   = best_r[1];
  assign out_data.best_cost_two   = best_r[2];
  assign out_data.best_cost_three = best_r[3];
  assign out_data.last            = run_last;

  // The final packet of a run is the only one left in the mask.
  a_last_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> $onehot(run_mask_r))
    else $error("last flagged with several packets pending");

  // Best costs never exceed infinity.
  a_best_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.best_cost_zero <= INFINITE_COST) &&
                  (out_data.best_cost_one <= INFINITE_COST) &&
                  (out_data.best_cost_two <= INFINITE_COST) &&
                  (out_data.best_cost_three <= INFINITE_COST))
    else $error("best cost above infinity");

  // A held request is not dropped while the output run is busy.
  a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r && !run_free |=> hold_valid_r)
    else $error("held request lost during output stall");

  // No packet is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
